>>> design/afcg_pkg.sv
package afcg_pkg;

   localparam int unsigned CREDIT_W = 13;
   localparam int unsigned CREDIT_MAX = 8191;
   localparam int unsigned NUM_W = 48;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_RATE_CODE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LITTLE_ENDIAN = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_LEFT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_RIGHT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MUTE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLOCK_HZ = 3'd5;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  data_byte;
      logic        end_of_call;
      logic [31:0] elapsed_cycles;
      logic        channel_active;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               frame_valid;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [12:0]        credit_left;
      logic [15:0]        peak_level;
      logic [31:0]        frames_total;
      logic               request_tick;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  rate_code;
      logic        little_endian;
      logic [15:0] gain_left;
      logic [15:0] gain_right;
      logic        mute;
      logic [31:0] clock_hz;
   } cfg_type;

   function automatic logic [15:0] rate_lookup(input logic [2:0] code);
      logic [15:0] r;
      case (code)
         3'd0: r = 16'd44100;
         3'd1: r = 16'd29400;
         3'd2: r = 16'd22050;
         3'd3: r = 16'd17640;
         3'd4: r = 16'd14700;
         3'd5: r = 16'd11025;
         3'd6: r = 16'd8820;
         default: r = 16'd7350;
      endcase
      return r;
   endfunction

endpackage

>>> design/afcg_fifo.sv
module afcg_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH_LOG2 = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH_LOG2:0] wr_ff, wr_in, rd_ff, rd_in;

   assign empty = (wr_ff == rd_ff);
   assign full = (wr_ff[DEPTH_LOG2-1:0] == rd_ff[DEPTH_LOG2-1:0]) &&
                 (wr_ff[DEPTH_LOG2] != rd_ff[DEPTH_LOG2]);
   assign pop_data = mem_ff[rd_ff[DEPTH_LOG2-1:0]];
   assign wr_in = wr_ff + ((push && !full) ? 1'b1 : 1'b0);
   assign rd_in = rd_ff + ((pop && !empty) ? 1'b1 : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push && !full) begin
         mem_ff[wr_ff[DEPTH_LOG2-1:0]] <= push_data;
      end
   end
endmodule

>>> design/afcg_divider.sv
module afcg_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [47:0] quotient,
   output logic [31:0] remainder
);
   logic [47:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] shifted;
   logic [33:0] diff;

   assign shifted = {rem_ff[31:0], quot_ff[47]};
   assign diff = {1'b0, shifted} - {2'b00, div_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         div_in = (divisor == '0) ? 32'd1 : divisor;
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quot_in = {quot_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted;
            quot_in = {quot_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;
   assign remainder = rem_ff[31:0];
endmodule

>>> design/afcg_back.sv
module afcg_back #(
   parameter int unsigned CAP_DIVISOR = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  afcg_pkg::cfg_type cfg,
   input  logic              item_valid,
   input  afcg_pkg::req_type item,
   output logic              item_take,
   output logic              rsp_push,
   output afcg_pkg::rsp_type rsp_data,
   input  logic              rsp_full
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV_START, ST_DIV_WAIT, ST_SCALE, ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [12:0] credit_ff, credit_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  part_ff [3];
   logic [7:0]  part_in [3];
   logic [1:0]  pcount_ff, pcount_in;
   logic [15:0] peak_ff, peak_in;
   logic [31:0] frames_ff, frames_in;
   logic        refused_ff, refused_in;
   afcg_pkg::req_type cur_ff, cur_in;
   afcg_pkg::rsp_type out_ff, out_in;
   logic [47:0] num_ff, num_in;
   logic signed [32:0] pl_ff, pl_in, pr_ff, pr_in;

   logic [15:0] rate;
   logic [15:0] cap;
   logic        div_done;
   logic [47:0] div_q;
   logic [31:0] div_r;
   logic [48:0] sum;
   logic [15:0] raw_l, raw_r;
   logic [15:0] ls, rs, ml, mr, pk;
   afcg_pkg::rsp_type out_view;

   assign rate = afcg_pkg::rate_lookup(cfg.rate_code);

   // credit cap per rate, folded to constants
   always_comb begin
      logic [15:0] c;
      case (cfg.rate_code)
         3'd0: c = 16'(44100 / CAP_DIVISOR);
         3'd1: c = 16'(29400 / CAP_DIVISOR);
         3'd2: c = 16'(22050 / CAP_DIVISOR);
         3'd3: c = 16'(17640 / CAP_DIVISOR);
         3'd4: c = 16'(14700 / CAP_DIVISOR);
         3'd5: c = 16'(11025 / CAP_DIVISOR);
         3'd6: c = 16'(8820 / CAP_DIVISOR);
         default: c = 16'(7350 / CAP_DIVISOR);
      endcase
      cap = (c > 16'(afcg_pkg::CREDIT_MAX)) ? 16'(afcg_pkg::CREDIT_MAX) : c;
   end

   afcg_divider u_div (
      .clock(clock), .reset(reset), .start(state_ff == ST_DIV_START),
      .dividend(num_ff), .divisor(cfg.clock_hz),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   assign sum = {36'd0, credit_ff} + {1'b0, div_q};
   assign item_take = (state_ff == ST_IDLE) && item_valid;
   assign rsp_push = (state_ff == ST_EMIT);
   assign rsp_data = out_view;

   // floor of product over 65536 is an arithmetic shift
   assign ls = pl_ff[31:16];
   assign rs = pr_ff[31:16];
   assign ml = ls[15] ? (16'd0 - ls) : ls;
   assign mr = rs[15] ? (16'd0 - rs) : rs;

   always_comb begin
      logic [15:0] p;
      p = peak_ff;
      if (ml > p) p = ml;
      if (mr > p) p = mr;
      pk = p;
   end

   always_comb begin
      if (cfg.little_endian) begin
         raw_l = {part_ff[1], part_ff[0]};
         raw_r = {cur_ff.data_byte, part_ff[2]};
      end else begin
         raw_l = {part_ff[0], part_ff[1]};
         raw_r = {part_ff[2], cur_ff.data_byte};
      end
   end

   always_comb begin
      state_in = state_ff;
      credit_in = credit_ff;
      remain_in = remain_ff;
      part_in = part_ff;
      pcount_in = pcount_ff;
      peak_in = peak_ff;
      frames_in = frames_ff;
      refused_in = refused_ff;
      cur_in = cur_ff;
      out_in = out_ff;
      num_in = num_ff;
      pl_in = pl_ff;
      pr_in = pr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               cur_in = item;
               state_in = (item.operation == afcg_pkg::OP_TICK) ? ST_MUL : ST_SCALE;
               out_in = '0;
               if (item.operation == afcg_pkg::OP_BYTE) begin
                  if (credit_ff != '0) begin
                     out_in.accepted = 1'b1;
                     if (pcount_ff != 2'd3) begin
                        part_in[pcount_ff] = item.data_byte;
                        pcount_in = pcount_ff + 2'd1;
                        state_in = ST_EMIT;
                     end
                  end else begin
                     refused_in = 1'b1;
                     state_in = ST_EMIT;
                  end
                  if (item.end_of_call) begin
                     out_in.request_tick = refused_in;
                     refused_in = 1'b0;
                  end
                  out_in.credit_left = credit_ff;
                  out_in.peak_level = peak_ff;
                  out_in.frames_total = frames_ff;
               end
            end
         end
         ST_MUL: begin
            num_in = 48'(cur_ff.elapsed_cycles) * 48'(rate) + {16'd0, remain_ff};
            state_in = ST_DIV_START;
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               remain_in = div_r;
               if (!cur_ff.channel_active) credit_in = '0;
               else if (sum > {33'd0, cap}) credit_in = cap[12:0];
               else credit_in = sum[12:0];
               out_in.credit_left = credit_in;
               out_in.peak_level = peak_ff;
               out_in.frames_total = frames_ff;
               state_in = ST_EMIT;
            end
         end
         ST_SCALE: begin
            // multiply now, shift and fold peak in emit stage below
            pl_in = $signed(raw_l) * $signed({1'b0, cfg.gain_left});
            pr_in = $signed(raw_r) * $signed({1'b0, cfg.gain_right});
            if (cfg.mute) begin
               pl_in = '0;
               pr_in = '0;
            end
            pcount_in = 2'd0;
            frames_in = frames_ff + 32'd1;
            credit_in = credit_ff - 13'd1;
            out_in.frame_valid = 1'b1;
            out_in.credit_left = credit_in;
            out_in.frames_total = frames_in;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               state_in = ST_IDLE;
               if (out_ff.frame_valid) peak_in = pk;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // rendered samples and peak derive from the product registers
   always_comb begin
      out_view = out_ff;
      if (out_ff.frame_valid) begin
         out_view.left_sample = ls;
         out_view.right_sample = rs;
         out_view.peak_level = pk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         credit_ff <= '0;
         remain_ff <= '0;
         pcount_ff <= '0;
         peak_ff <= '0;
         frames_ff <= '0;
         refused_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         credit_ff <= credit_in;
         remain_ff <= remain_in;
         pcount_ff <= pcount_in;
         peak_ff <= peak_in;
         frames_ff <= frames_in;
         refused_ff <= refused_in;
      end
      part_ff <= part_in;
      cur_ff <= cur_in;
      out_ff <= out_in;
      num_ff <= num_in;
      pl_ff <= pl_in;
      pr_ff <= pr_in;
   end
endmodule

>>> design/audio_frame_credit_gate.sv
// Paced stereo audio output with a frame-credit gate.
// Input channel (req_): push an item while full is low. A byte item offers
// one sample byte; a tick item grants credit from elapsed cycles and rate.
// Result channel (rsp_): exactly one result per item, oldest first, shown
// while empty is low and taken with pop.
// Configuration (csr_): write enable, index and 32-bit data; write only
// while the block is idle.
// An input queue decouples acceptance from the worker; results leave
// through a two-entry output queue, so a stalled receiver only blocks once
// that queue fills; then the worker holds its result and full rises.
// A plain byte passes the input queue, the IDLE and EMIT states and the
// output queue; a frame-completing byte also passes SCALE, and a tick
// passes MUL, DIV_START and DIV_WAIT, where the one-bit-per-cycle 48-bit
// credit divider runs. Items are worked one at a time.
// Reset clears credit, remainder, peak, frame count and the queues, and
// loads clock_hz with 100000000.
module audio_frame_credit_gate #(
   parameter int unsigned CAP_DIVISOR = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  afcg_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output afcg_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [afcg_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [afcg_pkg::CSR_DATA_W-1:0] csr_data
);
   afcg_pkg::cfg_type cfg_ff;
   afcg_pkg::req_type q_item;
   afcg_pkg::rsp_type b_rsp;
   logic q_empty, take, b_push, o_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_code <= '0;
         cfg_ff.little_endian <= 1'b0;
         cfg_ff.gain_left <= '0;
         cfg_ff.gain_right <= '0;
         cfg_ff.mute <= 1'b0;
         cfg_ff.clock_hz <= 32'd100000000;
      end else if (csr_write) begin
         unique case (csr_index)
            afcg_pkg::CSR_RATE_CODE: cfg_ff.rate_code <= csr_data[2:0];
            afcg_pkg::CSR_LITTLE_ENDIAN: cfg_ff.little_endian <= csr_data[0];
            afcg_pkg::CSR_GAIN_LEFT: cfg_ff.gain_left <= csr_data[15:0];
            afcg_pkg::CSR_GAIN_RIGHT: cfg_ff.gain_right <= csr_data[15:0];
            afcg_pkg::CSR_MUTE: cfg_ff.mute <= csr_data[0];
            afcg_pkg::CSR_CLOCK_HZ: cfg_ff.clock_hz <= csr_data;
            default: ;
         endcase
      end
   end

   afcg_fifo #(.WIDTH($bits(afcg_pkg::req_type)), .DEPTH_LOG2(1)) u_in (
      .clock(clock), .reset(reset), .push(push), .push_data(req_data),
      .full(full), .pop(take), .pop_data(q_item), .empty(q_empty)
   );

   afcg_back #(.CAP_DIVISOR(CAP_DIVISOR)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .item_valid(!q_empty),
      .item(q_item), .item_take(take), .rsp_push(b_push), .rsp_data(b_rsp),
      .rsp_full(o_full)
   );

   afcg_fifo #(.WIDTH($bits(afcg_pkg::rsp_type)), .DEPTH_LOG2(1)) u_out (
      .clock(clock), .reset(reset), .push(b_push), .push_data(b_rsp),
      .full(o_full), .pop(pop), .pop_data(rsp_data), .empty(empty)
   );
endmodule
